[rtl/core/go_back_n_sender_window_assert.svh]
// Assertion macros for the go-back-N sender window.
// Used by go_back_n_sender_window.sv; expects clk and rst_n in scope.
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// condition holds at every clock edge out of reset
`define GBN_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define GBN_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/gbn_pkg.sv]
// Shared types and constants for the go-back-N sender window.
// No dependencies.
package gbn_pkg;

    localparam int MAX_WINDOW_DEF = 15;
    localparam int TAG_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int SEQ_BITS   = 4;
    localparam int ACK_BITS   = 5;
    localparam int WC_BITS    = 4;
    localparam int CFG_BITS   = 16;
    localparam int RESULT_CAP = 16;
    localparam int CNT_BITS   = 5;

    localparam logic [ACK_BITS-1:0] ACK_NONE      = 5'd16;
    localparam logic [3:0]          WINDOW_RESET  = 4'd7;
    localparam logic [15:0]         TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_OFFER = 2'd1,
        OP_ACK   = 2'd2,
        OP_DONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_STATUS  = 3'd0,
        KIND_XMIT    = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_REFUSE  = 3'd3,
        KIND_BAD_ACK = 3'd4
    } kind_t;

    typedef enum logic {
        CFG_WINDOW  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHECK,
        S_ACKRES,
        S_RELEASE,
        S_TIMEOUT,
        S_XMIT,
        S_OFFER,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic stamp;
    } cell_ctl_t;

endpackage

[rtl/core/gbn_cell.sv]
// One window slot: tag, sequence number and send stamp.
// Depends on gbn_pkg. Shifts in its neighbor's slot on a pop.
module gbn_cell #(
    parameter int TAG_BITS  = gbn_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = gbn_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  gbn_pkg::cell_ctl_t            ctl,
    input  logic                          live,
    input  logic [gbn_pkg::ACK_BITS-1:0]  key,
    input  logic [TAG_BITS-1:0]           nb_tag,
    input  logic [gbn_pkg::SEQ_BITS-1:0]  nb_seq,
    input  logic [TIME_BITS-1:0]          nb_stamp,
    input  logic [TAG_BITS-1:0]           ld_tag,
    input  logic [gbn_pkg::SEQ_BITS-1:0]  ld_seq,
    input  logic [TIME_BITS-1:0]          now,
    output logic [TAG_BITS-1:0]           tag,
    output logic [gbn_pkg::SEQ_BITS-1:0]  seq,
    output logic [TIME_BITS-1:0]          stamp,
    output logic                          match
);

    logic [TAG_BITS-1:0]          tag_reg, tag_next;
    logic [gbn_pkg::SEQ_BITS-1:0] seq_reg, seq_next;
    logic [TIME_BITS-1:0]         stamp_reg, stamp_next;

    always_comb
    begin
        tag_next   = tag_reg;
        seq_next   = seq_reg;
        stamp_next = stamp_reg;
        if (ctl.shift)
        begin
            tag_next   = nb_tag;
            seq_next   = nb_seq;
            stamp_next = nb_stamp;
        end
        else
        begin
            if (ctl.load)
            begin
                tag_next = ld_tag;
                seq_next = ld_seq;
            end
            if (ctl.load || ctl.stamp)
            begin
                stamp_next = now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        seq_reg   <= seq_next;
        stamp_reg <= stamp_next;
    end

    assign tag   = tag_reg;
    assign seq   = seq_reg;
    assign stamp = stamp_reg;
    assign match = live && ({1'b0, seq_reg} == key);

endmodule

[rtl/core/gbn_chain.sv]
// Row of window slots, front at cell 0, with slot decode, read mux and ack search.
// Depends on gbn_pkg and gbn_cell.
module gbn_chain #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
    parameter int TAG_BITS   = gbn_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS  = gbn_pkg::TIME_BITS_DEF,
    parameter int IDX_BITS   = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          clk,
    input  gbn_pkg::cell_ctl_t            cmd,
    input  logic [IDX_BITS-1:0]           load_idx,
    input  logic [IDX_BITS-1:0]           stamp_idx,
    input  logic [IDX_BITS-1:0]           rd_idx,
    input  logic [IDX_BITS-1:0]           count,
    input  logic [gbn_pkg::ACK_BITS-1:0]  key,
    input  logic [TAG_BITS-1:0]           ld_tag,
    input  logic [gbn_pkg::SEQ_BITS-1:0]  ld_seq,
    input  logic [TIME_BITS-1:0]          now,
    output logic [TAG_BITS-1:0]           front_tag,
    output logic [gbn_pkg::SEQ_BITS-1:0]  front_seq,
    output logic [TIME_BITS-1:0]          front_stamp,
    output logic [TAG_BITS-1:0]           rd_tag,
    output logic [gbn_pkg::SEQ_BITS-1:0]  rd_seq,
    output logic                          found
);

    logic [TAG_BITS-1:0]          c_tag   [MAX_WINDOW+1];
    logic [gbn_pkg::SEQ_BITS-1:0] c_seq   [MAX_WINDOW+1];
    logic [TIME_BITS-1:0]         c_stamp [MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0]        c_match;

    // entry past the last cell feeds the tail on a pop
    assign c_tag[MAX_WINDOW]   = '0;
    assign c_seq[MAX_WINDOW]   = '0;
    assign c_stamp[MAX_WINDOW] = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        gbn_pkg::cell_ctl_t ctl;

        assign ctl.shift = cmd.shift;
        assign ctl.load  = cmd.load && (load_idx == IDX_BITS'(i));
        assign ctl.stamp = cmd.stamp && (stamp_idx == IDX_BITS'(i));

        gbn_cell #(
            .TAG_BITS  (TAG_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .live     (IDX_BITS'(i) < count),
            .key      (key),
            .nb_tag   (c_tag[i+1]),
            .nb_seq   (c_seq[i+1]),
            .nb_stamp (c_stamp[i+1]),
            .ld_tag   (ld_tag),
            .ld_seq   (ld_seq),
            .now      (now),
            .tag      (c_tag[i]),
            .seq      (c_seq[i]),
            .stamp    (c_stamp[i]),
            .match    (c_match[i])
        );
    end

    always_comb
    begin
        rd_tag = '0;
        rd_seq = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (rd_idx == IDX_BITS'(i))
            begin
                rd_tag = c_tag[i];
                rd_seq = c_seq[i];
            end
        end
    end

    assign front_tag   = c_tag[0];
    assign front_seq   = c_seq[0];
    assign front_stamp = c_stamp[0];
    assign found       = |c_match;

endmodule

[rtl/core/go_back_n_sender_window.sv]
// Go-back-N sender window, top level: event sequencer, config, result staging.
// Depends on gbn_pkg, gbn_chain, go_back_n_sender_window_assert.svh.
// One item at a time, accepted in idle only; an ack that frees k frames takes one cell
// shift per release. A result held back by m_tready stalls the item.
// Async active-low reset: window empty, window_size 7, timeout 1000; slots not cleared.
module go_back_n_sender_window #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
    parameter int TAG_BITS   = gbn_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS  = gbn_pkg::TIME_BITS_DEF,
    parameter int IN_W       = ((TAG_BITS + gbn_pkg::SEQ_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((TAG_BITS + gbn_pkg::SEQ_BITS + gbn_pkg::WC_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,  // frame_tag, ack_seq
    input  logic [1:0]                    s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,  // out_tag, out_seq, window_count
    output logic [3:0]                    m_tuser,  // kind, is_retransmit
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_idx,
    input  logic [gbn_pkg::CFG_BITS-1:0]  cfg_wdata
);

    localparam int IDX_BITS = $clog2(MAX_WINDOW + 1);
    localparam int CW       = (IDX_BITS > gbn_pkg::SEQ_BITS) ? IDX_BITS : gbn_pkg::SEQ_BITS;
    localparam int SB       = gbn_pkg::SEQ_BITS;
    localparam int AB       = gbn_pkg::ACK_BITS;
    localparam int WB       = gbn_pkg::WC_BITS;

    gbn_pkg::state_t        state_reg, state_next;
    gbn_pkg::op_t           op_reg, op_next;
    logic [TAG_BITS-1:0]    tag_in_reg, tag_in_next;
    logic [SB-1:0]          ack_in_reg, ack_in_next;
    logic [3:0]             ws_reg, ws_next;
    logic [15:0]            to_reg, to_next;
    logic [IDX_BITS-1:0]    fc_reg, fc_next;
    logic [IDX_BITS-1:0]    sp_reg, sp_next;
    logic [SB-1:0]          nseq_reg, nseq_next;
    logic [AB-1:0]          proc_reg, proc_next;
    logic [AB-1:0]          pend_reg, pend_next;
    logic                   busy_reg, busy_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic                   found_reg, found_next;
    logic [gbn_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;

    logic                   stg_valid_reg, stg_valid_next;
    gbn_pkg::kind_t         stg_kind_reg, stg_kind_next;
    logic [TAG_BITS-1:0]    stg_tag_reg, stg_tag_next;
    logic [SB-1:0]          stg_seq_reg, stg_seq_next;
    logic                   stg_retx_reg, stg_retx_next;
    logic [WB-1:0]          stg_wc_reg, stg_wc_next;

    logic                   out_valid_reg, out_valid_next;
    gbn_pkg::kind_t         out_kind_reg, out_kind_next;
    logic [TAG_BITS-1:0]    out_tag_reg, out_tag_next;
    logic [SB-1:0]          out_seq_reg, out_seq_next;
    logic                   out_retx_reg, out_retx_next;
    logic [WB-1:0]          out_wc_reg, out_wc_next;
    logic                   out_last_reg, out_last_next;

    gbn_pkg::cell_ctl_t     cmd;
    logic [TAG_BITS-1:0]    front_tag, rd_tag;
    logic [SB-1:0]          front_seq, rd_seq;
    logic [TIME_BITS-1:0]   front_stamp;
    logic                   found_w;

    logic                   emit;
    gbn_pkg::kind_t         e_kind;
    logic [TAG_BITS-1:0]    e_tag;
    logic [SB-1:0]          e_seq;
    logic                   e_retx;
    logic [WB-1:0]          e_wc;

    logic                   out_free, go, accept, full, timed_out;
    logic [TIME_BITS-1:0]   age;

    gbn_chain #(
        .MAX_WINDOW (MAX_WINDOW),
        .TAG_BITS   (TAG_BITS),
        .TIME_BITS  (TIME_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_chain (
        .clk         (clk),
        .cmd         (cmd),
        .load_idx    (fc_reg),
        .stamp_idx   (sp_reg),
        .rd_idx      (sp_reg),
        .count       (fc_reg),
        .key         (pend_reg),
        .ld_tag      (tag_in_reg),
        .ld_seq      (nseq_reg),
        .now         (now_reg),
        .front_tag   (front_tag),
        .front_seq   (front_seq),
        .front_stamp (front_stamp),
        .rd_tag      (rd_tag),
        .rd_seq      (rd_seq),
        .found       (found_w)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign go        = !stg_valid_reg || out_free;
    assign s_tready  = (state_reg == gbn_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (CW'(fc_reg) >= CW'(ws_reg)) || (CW'(fc_reg) >= CW'(MAX_WINDOW));
    assign age       = now_reg - front_stamp;
    assign timed_out = (fc_reg != '0) && (age >= TIME_BITS'(to_reg));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tag_in_next    = tag_in_reg;
        ack_in_next    = ack_in_reg;
        ws_next        = ws_reg;
        to_next        = to_reg;
        fc_next        = fc_reg;
        sp_next        = sp_reg;
        nseq_next      = nseq_reg;
        proc_next      = proc_reg;
        pend_next      = pend_reg;
        busy_next      = busy_reg;
        now_next       = now_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        stg_valid_next = stg_valid_reg;
        stg_kind_next  = stg_kind_reg;
        stg_tag_next   = stg_tag_reg;
        stg_seq_next   = stg_seq_reg;
        stg_retx_next  = stg_retx_reg;
        stg_wc_next    = stg_wc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_tag_next   = out_tag_reg;
        out_seq_next   = out_seq_reg;
        out_retx_next  = out_retx_reg;
        out_wc_next    = out_wc_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;
        emit           = 1'b0;
        e_kind         = gbn_pkg::KIND_STATUS;
        e_tag          = '0;
        e_seq          = '0;
        e_retx         = 1'b0;
        e_wc           = WB'(fc_reg);

        if (cfg_we)
        begin
            unique case (gbn_pkg::cfg_reg_t'(cfg_idx))
                gbn_pkg::CFG_WINDOW:  ws_next = cfg_wdata[3:0];
                gbn_pkg::CFG_TIMEOUT: to_next = cfg_wdata[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            gbn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = gbn_pkg::op_t'(s_tuser);
                    tag_in_next = s_tdata[TAG_BITS-1:0];
                    ack_in_next = s_tdata[TAG_BITS +: SB];
                    cnt_next    = '0;
                    state_next  = gbn_pkg::S_DISPATCH;
                end
            end
            gbn_pkg::S_DISPATCH:
            begin
                unique case (op_reg)
                    gbn_pkg::OP_TICK:
                    begin
                        now_next   = now_reg + 1'b1;
                        state_next = busy_reg ? gbn_pkg::S_FINISH : gbn_pkg::S_CHECK;
                    end
                    gbn_pkg::OP_OFFER:
                    begin
                        state_next = busy_reg ? gbn_pkg::S_OFFER : gbn_pkg::S_CHECK;
                    end
                    gbn_pkg::OP_ACK:
                    begin
                        if ({1'b0, ack_in_reg} != proc_reg)
                        begin
                            pend_next  = {1'b0, ack_in_reg};
                            state_next = busy_reg ? gbn_pkg::S_FINISH : gbn_pkg::S_CHECK;
                        end
                        else
                        begin
                            state_next = gbn_pkg::S_FINISH;
                        end
                    end
                    gbn_pkg::OP_DONE:
                    begin
                        if (busy_reg)
                        begin
                            if (sp_reg < fc_reg)
                            begin
                                cmd.stamp = 1'b1;
                                sp_next   = sp_reg + 1'b1;
                            end
                            busy_next  = 1'b0;
                            state_next = gbn_pkg::S_CHECK;
                        end
                        else
                        begin
                            state_next = gbn_pkg::S_FINISH;
                        end
                    end
                    default: ;
                endcase
            end
            gbn_pkg::S_CHECK:
            begin
                if (pend_reg != proc_reg)
                begin
                    found_next = found_w;
                    state_next = gbn_pkg::S_ACKRES;
                end
                else
                begin
                    state_next = gbn_pkg::S_TIMEOUT;
                end
            end
            gbn_pkg::S_ACKRES:
            begin
                if (found_reg)
                begin
                    state_next = gbn_pkg::S_RELEASE;
                end
                else if (go)
                begin
                    emit       = 1'b1;
                    e_kind     = gbn_pkg::KIND_BAD_ACK;
                    e_seq      = pend_reg[SB-1:0];
                    pend_next  = proc_reg;
                    state_next = gbn_pkg::S_TIMEOUT;
                end
            end
            gbn_pkg::S_RELEASE:
            begin
                if (go)
                begin
                    cmd.shift = 1'b1;
                    fc_next   = fc_reg - 1'b1;
                    if (sp_reg != '0)
                    begin
                        sp_next = sp_reg - 1'b1;
                    end
                    emit   = 1'b1;
                    e_kind = gbn_pkg::KIND_RELEASE;
                    e_tag  = front_tag;
                    e_seq  = front_seq;
                    e_wc   = WB'(fc_next);
                    if (({1'b0, front_seq} == pend_reg) || (fc_reg == IDX_BITS'(1)))
                    begin
                        proc_next  = pend_reg;
                        state_next = gbn_pkg::S_TIMEOUT;
                    end
                end
            end
            gbn_pkg::S_TIMEOUT:
            begin
                if (timed_out)
                begin
                    sp_next = '0;
                end
                state_next = gbn_pkg::S_XMIT;
            end
            gbn_pkg::S_XMIT:
            begin
                if (sp_reg < fc_reg)
                begin
                    if (go)
                    begin
                        emit      = 1'b1;
                        e_kind    = gbn_pkg::KIND_XMIT;
                        e_tag     = rd_tag;
                        e_seq     = rd_seq;
                        e_retx    = 1'b1;
                        busy_next = 1'b1;
                        state_next = (op_reg == gbn_pkg::OP_OFFER) ?
                                     gbn_pkg::S_OFFER : gbn_pkg::S_FINISH;
                    end
                end
                else
                begin
                    state_next = (op_reg == gbn_pkg::OP_OFFER) ?
                                 gbn_pkg::S_OFFER : gbn_pkg::S_FINISH;
                end
            end
            gbn_pkg::S_OFFER:
            begin
                if (go)
                begin
                    emit = 1'b1;
                    if (busy_reg || full)
                    begin
                        e_kind = gbn_pkg::KIND_REFUSE;
                        e_tag  = tag_in_reg;
                    end
                    else
                    begin
                        cmd.load  = 1'b1;
                        nseq_next = (nseq_reg >= ws_reg) ? '0 : nseq_reg + 1'b1;
                        sp_next   = fc_reg;
                        fc_next   = fc_reg + 1'b1;
                        busy_next = 1'b1;
                        e_kind    = gbn_pkg::KIND_XMIT;
                        e_tag     = tag_in_reg;
                        e_seq     = nseq_reg;
                        e_wc      = WB'(fc_next);
                    end
                    state_next = gbn_pkg::S_FINISH;
                end
            end
            gbn_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (stg_valid_reg)
                    begin
                        out_kind_next = stg_kind_reg;
                        out_tag_next  = stg_tag_reg;
                        out_seq_next  = stg_seq_reg;
                        out_retx_next = stg_retx_reg;
                        out_wc_next   = stg_wc_reg;
                    end
                    else
                    begin
                        out_kind_next = gbn_pkg::KIND_STATUS;
                        out_tag_next  = '0;
                        out_seq_next  = '0;
                        out_retx_next = 1'b0;
                        out_wc_next   = WB'(fc_reg);
                    end
                    stg_valid_next = 1'b0;
                    state_next     = gbn_pkg::S_IDLE;
                end
            end
            default: state_next = gbn_pkg::S_IDLE;
        endcase

        // one result held back so the final one of an item can carry last
        if (emit && (cnt_reg < gbn_pkg::CNT_BITS'(gbn_pkg::RESULT_CAP)))
        begin
            cnt_next = cnt_reg + 1'b1;
            if (stg_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_last_next  = 1'b0;
                out_kind_next  = stg_kind_reg;
                out_tag_next   = stg_tag_reg;
                out_seq_next   = stg_seq_reg;
                out_retx_next  = stg_retx_reg;
                out_wc_next    = stg_wc_reg;
            end
            stg_valid_next = 1'b1;
            stg_kind_next  = e_kind;
            stg_tag_next   = e_tag;
            stg_seq_next   = e_seq;
            stg_retx_next  = e_retx;
            stg_wc_next    = e_wc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbn_pkg::S_IDLE;
            ws_reg        <= gbn_pkg::WINDOW_RESET;
            to_reg        <= gbn_pkg::TIMEOUT_RESET;
            fc_reg        <= '0;
            sp_reg        <= '0;
            nseq_reg      <= '0;
            proc_reg      <= gbn_pkg::ACK_NONE;
            pend_reg      <= gbn_pkg::ACK_NONE;
            busy_reg      <= 1'b0;
            now_reg       <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            to_reg        <= to_next;
            fc_reg        <= fc_next;
            sp_reg        <= sp_next;
            nseq_reg      <= nseq_next;
            proc_reg      <= proc_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
            now_reg       <= now_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tag_in_reg   <= tag_in_next;
        ack_in_reg   <= ack_in_next;
        stg_kind_reg <= stg_kind_next;
        stg_tag_reg  <= stg_tag_next;
        stg_seq_reg  <= stg_seq_next;
        stg_retx_reg <= stg_retx_next;
        stg_wc_reg   <= stg_wc_next;
        out_kind_reg <= out_kind_next;
        out_tag_reg  <= out_tag_next;
        out_seq_reg  <= out_seq_next;
        out_retx_reg <= out_retx_next;
        out_wc_reg   <= out_wc_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_wc_reg, out_seq_reg, out_tag_reg});
    assign m_tuser  = {out_retx_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

`include "go_back_n_sender_window_assert.svh"

    `GBN_ASSERT_HOLDS(a_fc_bound, CW'(fc_reg) <= CW'(MAX_WINDOW), "frame count past window")
    `GBN_ASSERT_HOLDS(a_sp_bound, sp_reg <= fc_reg, "send pointer past frame count")
    `GBN_ASSERT_HOLDS(a_busy_sp, !busy_reg || (sp_reg < fc_reg), "busy with no frame in flight")
    `GBN_ASSERT_NEXT(a_accept, s_tvalid && s_tready, state_reg == gbn_pkg::S_DISPATCH, "accept lost")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for go_back_n_sender_window: stream driver and monitor,
// an in-bench window predictor, directed events, then randomized link traffic.
// Depends on gbn_pkg and the go_back_n_sender_window RTL.
module tb_top;
    import gbn_pkg::*;

    localparam int MAXW        = MAX_WINDOW_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        op_t         op;
        logic [15:0] tag;
        logic [3:0]  ack;
    } link_event_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag;
        logic [3:0]  seq;
        logic        retx;
        logic [3:0]  wcount;
        logic        last;
    } sender_result_t;

    typedef struct packed {
        logic [MAXW-1:0][15:0] tag;
        logic [MAXW-1:0][3:0]  seq;
        logic [MAXW-1:0][31:0] stamp;
        logic [4:0]            count;
        logic [4:0]            sendp;
        logic [3:0]            nseq;
        logic [4:0]            done_ack;
        logic [4:0]            held_ack;
        logic                  busy;
        logic [31:0]           now;
        logic [3:0]            wsize;
        logic [15:0]           tmo;
    } window_state_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_wdata = '0;

    link_event_t    pending_events[$];
    sender_result_t expected_results[$];
    window_state_t  sender_state;
    link_event_t    drv_event;

    int events_queued;
    int events_accepted;
    int events_counted;
    int results_seen;
    int err_count;
    int settings_used;
    int tx_gap;
    int rx_wait;
    int stall_cycles;
    int kind_seen[5];
    bit tx_burst;
    bit rx_burst;

    go_back_n_sender_window uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- window predictor ----------------

    function automatic void add_result(ref sender_result_t q[$], input kind_t kind,
                                       input logic [15:0] tag, input logic [3:0] seq,
                                       input logic retx, input logic [4:0] count);
        sender_result_t r;
        r.kind   = kind;
        r.tag    = tag;
        r.seq    = seq;
        r.retx   = retx;
        r.wcount = count[3:0];
        r.last   = 1'b0;
        q.push_back(r);
    endfunction

    function automatic void drop_front(inout window_state_t st);
        for (int i = 1; i < MAXW; i++)
        begin
            if (i < st.count)
            begin
                st.tag[i-1]   = st.tag[i];
                st.seq[i-1]   = st.seq[i];
                st.stamp[i-1] = st.stamp[i];
            end
        end
        if (st.count > 0)
            st.count = st.count - 1;
        if (st.sendp > 0)
            st.sendp = st.sendp - 1;
    endfunction

    // idle work: pending ack, timeout of the oldest frame, (re)transmit start
    function automatic void settle_window(inout window_state_t st, ref sender_result_t q[$]);
        bit          found;
        bit          more;
        logic [15:0] t;
        logic [3:0]  s;
        logic [31:0] age;
        if (st.held_ack != st.done_ack)
        begin
            found = 1'b0;
            for (int i = 0; i < MAXW; i++)
                if (i < st.count && {1'b0, st.seq[i]} == st.held_ack)
                    found = 1'b1;
            if (!found)
            begin
                add_result(q, KIND_BAD_ACK, 16'd0, st.held_ack[3:0], 1'b0, st.count);
                st.held_ack = st.done_ack;
            end
            else
            begin
                more = 1'b1;
                while (more)
                begin
                    t = st.tag[0];
                    s = st.seq[0];
                    drop_front(st);
                    add_result(q, KIND_RELEASE, t, s, 1'b0, st.count);
                    more = ({1'b0, s} != st.held_ack) && (st.count > 0);
                end
                st.done_ack = st.held_ack;
            end
        end
        age = st.now - st.stamp[0];
        if (st.count > 0 && age >= {16'd0, st.tmo})
            st.sendp = '0;
        if (st.sendp < st.count)
        begin
            add_result(q, KIND_XMIT, st.tag[st.sendp], st.seq[st.sendp], 1'b1, st.count);
            st.busy = 1'b1;
        end
    endfunction

    function automatic void refuse_offer(inout window_state_t st, ref sender_result_t q[$],
                                         input logic [15:0] tag);
        add_result(q, KIND_REFUSE, tag, 4'd0, 1'b0, st.count);
    endfunction

    // computes the results of one link event and advances the sender state
    function automatic void sender_response(inout window_state_t st, input link_event_t ev,
                                            ref sender_result_t q[$]);
        int first;
        first = q.size();
        case (ev.op)
            OP_TICK:
            begin
                st.now = st.now + 1;
                if (!st.busy)
                    settle_window(st, q);
            end
            OP_OFFER:
            begin
                if (st.busy)
                    refuse_offer(st, q, ev.tag);
                else
                begin
                    settle_window(st, q);
                    if (st.busy || st.count >= {1'b0, st.wsize})
                        refuse_offer(st, q, ev.tag);
                    else
                    begin
                        st.sendp             = st.count;
                        st.tag[st.count]     = ev.tag;
                        st.seq[st.count]     = st.nseq;
                        st.stamp[st.count]   = st.now;
                        st.count             = st.count + 1;
                        add_result(q, KIND_XMIT, ev.tag, st.nseq, 1'b0, st.count);
                        st.nseq = (st.nseq >= st.wsize) ? 4'd0 : st.nseq + 4'd1;
                        st.busy = 1'b1;
                    end
                end
            end
            OP_ACK:
            begin
                if ({1'b0, ev.ack} != st.done_ack)
                begin
                    st.held_ack = {1'b0, ev.ack};
                    if (!st.busy)
                        settle_window(st, q);
                end
            end
            default:
            begin
                if (st.busy)
                begin
                    if (st.sendp < st.count)
                    begin
                        st.stamp[st.sendp] = st.now;
                        st.sendp = st.sendp + 1;
                    end
                    st.busy = 1'b0;
                    settle_window(st, q);
                end
            end
        endcase
        if (q.size() == first)
            add_result(q, KIND_STATUS, 16'd0, 4'd0, 1'b0, st.count);
        q[q.size()-1].last = 1'b1;
    endfunction

    // ---------------- stimulus planning ----------------

    function automatic bit event_ignored(input window_state_t st, input link_event_t ev);
        return (ev.op == OP_DONE && !st.busy) ||
               (ev.op == OP_ACK && {1'b0, ev.ack} == st.done_ack);
    endfunction

    // mostly protocol-like traffic shaped by the current window, some noise
    function automatic link_event_t plan_event(input window_state_t st);
        link_event_t ev;
        int          r;
        ev.tag = $urandom_range(0, 65535);
        if ($urandom_range(0, 15) == 0)
            ev.tag = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        ev.ack = $urandom_range(0, 15);
        r = $urandom_range(0, 99);
        if (r < 8)
            ev.op = op_t'($urandom_range(0, 3));
        else if (st.busy)
            ev.op = (r < 60) ? OP_DONE : (r < 75) ? OP_TICK : (r < 88) ? OP_ACK : OP_OFFER;
        else
            ev.op = (r < 45) ? OP_OFFER : (r < 70) ? OP_ACK : (r < 95) ? OP_TICK : OP_DONE;
        if (ev.op == OP_ACK && st.count != 0 && $urandom_range(0, 4) != 0)
            ev.ack = st.seq[$urandom_range(0, st.count - 1)];
        return ev;
    endfunction

    task automatic push_event(input op_t op, input logic [15:0] tag, input logic [3:0] ack);
        link_event_t ev;
        ev.op  = op;
        ev.tag = tag;
        ev.ack = ack;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic fill_random(input int n);
        window_state_t  shadow;
        link_event_t    ev;
        sender_result_t scratch[$];
        int             counted;
        shadow  = sender_state;
        counted = 0;
        while (counted < n)
        begin
            ev = plan_event(shadow);
            if (!event_ignored(shadow, ev))
                counted++;
            sender_response(shadow, ev, scratch);
            scratch.delete();
            pending_events.push_back(ev);
            events_queued++;
        end
        events_counted += n;
    endtask

    // waits until every item is in and every result is out
    task automatic wait_quiet();
        while (events_accepted != events_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW)
            sender_state.wsize = val[3:0];
        else
            sender_state.tmo = val;
    endtask

    task automatic configure(input logic [3:0] win, input logic [15:0] tmo);
        wait_quiet();
        write_reg(CFG_WINDOW, {12'd0, win});
        write_reg(CFG_TIMEOUT, tmo);
        settings_used++;
    endtask

    // ---------------- checking ----------------

    task automatic report(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at %0t, result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    task automatic check_result();
        sender_result_t want;
        if (expected_results.size() == 0)
        begin
            report("result with nothing pending, kind", m_tuser[2:0], 0);
            return;
        end
        want = expected_results.pop_front();
        kind_seen[want.kind]++;
        if (m_tuser[2:0] != want.kind)
            report("kind", m_tuser[2:0], want.kind);
        if (m_tuser[3] != want.retx)
            report("is_retransmit", m_tuser[3], want.retx);
        if (m_tdata[15:0] != want.tag)
            report("out_tag", m_tdata[15:0], want.tag);
        if (m_tdata[19:16] != want.seq)
            report("out_seq", m_tdata[19:16], want.seq);
        if (m_tdata[23:20] != want.wcount)
            report("window_count", m_tdata[23:20], want.wcount);
        if (m_tlast != want.last)
            report("last", m_tlast, want.last);
    endtask

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sender_response(sender_state, drv_event, expected_results);
                events_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    drv_event = pending_events.pop_front();
                    s_tdata   <= {4'd0, drv_event.ack, drv_event.tag};
                    s_tuser   <= drv_event.op;
                    s_tvalid  <= 1'b1;
                    tx_gap    = tx_burst ? 0 : $urandom_range(0, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
                results_seen++;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
                // long hold-offs so the block backs up into its input
                if (results_seen == 120 || results_seen == 400)
                    rx_wait = 300;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no progress for %0d cycles, %0d results still pending",
                         stall_cycles, expected_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------

    logic [3:0]  phase_win[8] = '{4'd15, 4'd1, 4'd4, 4'd15, 4'd3, 4'd8, 4'd1, 4'd6};
    logic [15:0] phase_tmo[8] = '{16'd65535, 16'd1, 16'd3, 16'd12, 16'd65535, 16'd5,
                                  16'd30, 16'd2};

    initial
    begin
        sender_state          = '0;
        sender_state.done_ack = ACK_NONE;
        sender_state.held_ack = ACK_NONE;
        sender_state.wsize    = WINDOW_RESET;
        sender_state.tmo      = TIMEOUT_RESET;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle done, bad ack, busy refusal, held ack, repeated ack
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_TICK,  16'h0000, 4'd0);
        push_event(OP_ACK,   16'h0000, 4'd5);
        push_event(OP_OFFER, 16'hFFFF, 4'd0);
        push_event(OP_OFFER, 16'h0000, 4'd0);
        push_event(OP_ACK,   16'h0000, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_OFFER, 16'h1234, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_OFFER, 16'hABCD, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_ACK,   16'h0000, 4'd15);
        push_event(OP_ACK,   16'h0000, 4'd0);
        push_event(OP_ACK,   16'h0000, 4'd1);
        push_event(OP_TICK,  16'h0000, 4'd0);

        // short timeout with a frame still out: retransmit starts during an offer,
        // then a full window, timeouts and a multi-frame release
        configure(4'd2, 16'd1);
        push_event(OP_OFFER, 16'h5555, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_OFFER, 16'h00FF, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_OFFER, 16'h8000, 4'd0);
        push_event(OP_TICK,  16'h0000, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_DONE,  16'h0000, 4'd0);
        push_event(OP_TICK,  16'h0000, 4'd0);
        push_event(OP_ACK,   16'h0000, 4'd0);

        for (int p = 0; p < 8; p++)
        begin
            configure(phase_win[p], phase_tmo[p]);
            tx_burst = (p == 3);
            rx_burst = (p == 3 || p == 5);
            fill_random(55);
        end
        wait_quiet();
        repeat (24) @(posedge clk);

        $display("%0d link events sent (%0d random, counted), %0d results checked, %0d settings",
                 events_accepted, events_counted, results_seen, settings_used + 1);
        $display("kinds: status %0d, transmit %0d, release %0d, refused %0d, bad ack %0d; %0d errors",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], err_count);
        if (err_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
